// ----- hw/rtl/depth_disparity_line_shift_macros.svh -----
// Assertion helpers shared by the line shift RTL.
`ifndef DEPTH_DISPARITY_LINE_SHIFT_MACROS_SVH
`define DEPTH_DISPARITY_LINE_SHIFT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DDLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ddls_pkg.sv -----
package ddls_pkg;

   localparam int DEPTH_W        = 16;
   localparam int BF_W           = 32;
   localparam int LW_W           = 12;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_LINE_WIDTH = 640;
   localparam int MIN_LINE_WIDTH = 2;
   // numerator bf + 128*d, sign-extended
   localparam int NUM_W          = BF_W + 2;
   // fraction bits of bf, dropped before the divide
   localparam int Q_SHIFT        = 8;
   // magnitude of numerator / 256 fits in this many bits
   localparam int DVD_W          = 24;
   localparam int DIV_CNT_W      = $clog2(DVD_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_FOCAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH     = 2'd1;

   typedef struct packed {
      logic clear_init;
      logic clear_step;
      logic accept;
      logic rd_out;
      logic emit;
      logic div_start;
      logic div_step;
      logic chk;
      logic rd_a;
      logic wr_a;
      logic rd_b;
      logic wr_b;
      logic line_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic skip;
      logic pending;
      logic out_free;
      logic scatter;
      logic div_done;
      logic in_range;
      logic first_wins;
   } status_type;

endpackage

// ----- hw/rtl/ddls_req_if.sv -----
interface ddls_req_if;
   import ddls_pkg::*;

   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_in;
   logic               drain;

   modport source (output valid, output depth_in, output drain, input ready);
   modport sink (input valid, input depth_in, input drain, output ready);

endinterface

// ----- hw/rtl/ddls_rsp_if.sv -----
interface ddls_rsp_if;
   import ddls_pkg::*;

   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] aligned_depth;
   logic               line_end;

   modport source (output valid, output aligned_depth, output line_end, input ready);
   modport sink (input valid, input aligned_depth, input line_end, output ready);

endinterface

// ----- hw/rtl/ddls_datapath.sv -----
`include "depth_disparity_line_shift_macros.svh"

module ddls_datapath #(
   parameter int MAX_WIDTH = ddls_pkg::DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ddls_pkg::cmd_type            cmd,
   output ddls_pkg::status_type         status,
   input  logic [ddls_pkg::DEPTH_W-1:0] req_depth,
   input  logic                         req_drain,
   input  logic [ddls_pkg::BF_W-1:0]    baseline_focal,
   input  logic [$clog2(MAX_WIDTH)-1:0] last_col,
   ddls_rsp_if.source                   rsp_chan
);
   import ddls_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int AW = CW + 1;
   localparam int MD = 2 ** AW;
   localparam int SW = ((CW > DVD_W) ? CW : DVD_W) + 2;

   logic [DEPTH_W-1:0] mem [MD];
   logic [DEPTH_W-1:0] rdata_ff;

   logic [DEPTH_W-1:0] depth_ff;
   logic               drain_ff;
   logic [CW-1:0]      col_ff;
   logic               bank_ff;
   logic               pending_ff;
   logic               has_data_ff;
   logic [AW-1:0]      clr_cnt_ff;

   logic               out_valid_ff;
   logic [DEPTH_W-1:0] out_depth_ff;
   logic               out_end_ff;

   logic [DEPTH_W-1:0] rem_ff;
   logic [DVD_W-1:0]   dvd_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic               neg_ff;
   logic               first_ff;

   logic [AW-1:0]      addr_a_ff;
   logic [AW-1:0]      addr_b_ff;
   logic               in_range_ff;

   logic               at_last;
   logic               out_free;
   logic [AW-1:0]      out_addr;
   logic [NUM_W-1:0]   numer;
   logic [NUM_W-1:0]   mag;
   logic [DEPTH_W:0]   rem_shift;
   logic               rem_ge;
   logic signed [SW-1:0] qmag;
   logic signed [SW-1:0] qs;
   logic signed [SW-1:0] s_val;
   logic signed [SW-1:0] last_val;
   logic               range_first;
   logic               range_last;
   logic [CW-1:0]      sa;
   logic [CW-1:0]      sb;

   logic               we;
   logic [AW-1:0]      waddr;
   logic [DEPTH_W-1:0] wdata;
   logic               re;
   logic [AW-1:0]      raddr;

   assign at_last  = (col_ff == last_col);
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign out_addr = {~bank_ff, col_ff};

   // numerator and its magnitude; the divider takes the magnitude scaled down by 256
   assign numer = {{2{baseline_focal[BF_W-1]}}, baseline_focal}
                + {{(NUM_W-DEPTH_W-7){1'b0}}, depth_ff, 7'b0};
   assign mag   = numer[NUM_W-1] ? (~numer + 1'b1) : numer;

   // one restoring step per cycle
   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, depth_ff});

   // target column and bound tests
   assign qmag     = signed'({{(SW-DVD_W){1'b0}}, dvd_ff});
   assign qs       = neg_ff ? -qmag : qmag;
   assign s_val    = signed'({{(SW-CW){1'b0}}, col_ff}) + qs;
   assign last_val = signed'({{(SW-CW){1'b0}}, last_col});
   assign range_first = !s_val[SW-1] && (s_val < last_val);
   assign range_last  = (s_val > 0) && (s_val <= last_val);
   assign sa = s_val[CW-1:0];
   assign sb = first_ff ? CW'(sa + 1'b1) : CW'(sa - 1'b1);

   // memory write select
   always_comb begin
      we    = 1'b0;
      waddr = clr_cnt_ff;
      wdata = '0;
      if (cmd.clear_step) begin
         we = 1'b1;
      end else if (cmd.emit) begin
         we    = 1'b1;
         waddr = out_addr;
      end else if (cmd.wr_a) begin
         we    = !first_ff || (rdata_ff == '0);
         waddr = addr_a_ff;
         wdata = depth_ff;
      end else if (cmd.wr_b) begin
         we    = !first_ff || (rdata_ff == '0);
         waddr = addr_b_ff;
         wdata = depth_ff;
      end
   end

   // memory read select
   always_comb begin
      re    = cmd.rd_out || cmd.rd_a || cmd.rd_b;
      raddr = addr_a_ff;
      if (cmd.rd_out) begin
         raddr = out_addr;
      end else if (cmd.rd_b) begin
         raddr = addr_b_ff;
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // line control
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_init) begin
         col_ff      <= '0;
         bank_ff     <= 1'b0;
         pending_ff  <= 1'b0;
         has_data_ff <= 1'b0;
         clr_cnt_ff  <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= AW'(clr_cnt_ff + 1'b1);
         end
         if (cmd.line_step) begin
            if (at_last) begin
               bank_ff     <= ~bank_ff;
               pending_ff  <= has_data_ff || !drain_ff;
               has_data_ff <= 1'b0;
               col_ff      <= '0;
            end else begin
               has_data_ff <= has_data_ff || !drain_ff;
               col_ff      <= CW'(col_ff + 1'b1);
            end
         end
      end
   end

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         depth_ff <= req_depth;
         drain_ff <= req_drain;
      end
   end

   // divider and placement
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff     <= '0;
         dvd_ff     <= mag[DVD_W+Q_SHIFT-1:Q_SHIFT];
         div_cnt_ff <= '0;
         neg_ff     <= numer[NUM_W-1];
         first_ff   <= !baseline_focal[BF_W-1] && (baseline_focal != '0);
      end else if (cmd.div_step) begin
         rem_ff     <= rem_ge ? DEPTH_W'(rem_shift - {1'b0, depth_ff})
                              : rem_shift[DEPTH_W-1:0];
         dvd_ff     <= {dvd_ff[DVD_W-2:0], rem_ge};
         div_cnt_ff <= DIV_CNT_W'(div_cnt_ff + 1'b1);
      end
      if (cmd.chk) begin
         in_range_ff <= first_ff ? range_first : range_last;
         addr_a_ff   <= {bank_ff, sa};
         addr_b_ff   <= {bank_ff, sb};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_init) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_depth_ff <= rdata_ff;
         out_end_ff   <= at_last;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.aligned_depth = out_depth_ff;
   assign rsp_chan.line_end      = out_end_ff;

   assign status.clear_last = (clr_cnt_ff == AW'(MD - 1));
   assign status.skip       = req_drain && !pending_ff && !has_data_ff;
   assign status.pending    = pending_ff;
   assign status.out_free   = out_free;
   assign status.scatter    = !drain_ff && (depth_ff != '0);
   assign status.div_done   = (div_cnt_ff == DIV_CNT_W'(DVD_W));
   assign status.in_range   = in_range_ff;
   assign status.first_wins = first_ff;

   `DDLS_ASSERT_IMP(a_write_in_line, clock, reset, cmd.wr_a || cmd.wr_b, in_range_ff, "scatter write outside line")
   `DDLS_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, out_free, "result loaded over a held beat")
   `DDLS_ASSERT_NXT(a_line_wrap, clock, reset, cmd.line_step && at_last && !cmd.clear_init, (col_ff == '0) && (bank_ff != $past(bank_ff)), "line end did not swap banks")

endmodule

// ----- hw/rtl/ddls_ctrl.sv -----
`include "depth_disparity_line_shift_macros.svh"

module ddls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ddls_pkg::status_type status,
   output ddls_pkg::cmd_type    cmd
);
   import ddls_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_OUT,
      ST_EMIT,
      ST_SCAT,
      ST_DIV,
      ST_CHK,
      ST_PLACE,
      ST_RD_A,
      ST_WR_A,
      ST_RD_B,
      ST_WR_B,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      accept;

   assign accept    = ready_ff && req_valid;
   assign req_ready = ready_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (restart) begin
         cmd.clear_init = 1'b1;
         state_in       = ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               cmd.clear_step = 1'b1;
               if (status.clear_last) state_in = ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd.accept = 1'b1;
                  if (status.skip) begin
                     state_in = ST_IDLE;
                  end else if (status.pending) begin
                     state_in = ST_RD_OUT;
                  end else begin
                     state_in = ST_SCAT;
                  end
               end
            end
            ST_RD_OUT: begin
               cmd.rd_out = 1'b1;
               state_in   = ST_EMIT;
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ST_SCAT;
               end
            end
            ST_SCAT: begin
               if (status.scatter) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_FIN;
               end
            end
            ST_DIV: begin
               if (status.div_done) begin
                  state_in = ST_CHK;
               end else begin
                  cmd.div_step = 1'b1;
               end
            end
            ST_CHK: begin
               cmd.chk  = 1'b1;
               state_in = ST_PLACE;
            end
            ST_PLACE: begin
               if (!status.in_range) begin
                  state_in = ST_FIN;
               end else if (status.first_wins) begin
                  state_in = ST_RD_A;
               end else begin
                  state_in = ST_WR_A;
               end
            end
            ST_RD_A: begin
               cmd.rd_a = 1'b1;
               state_in = ST_WR_A;
            end
            ST_WR_A: begin
               cmd.wr_a = 1'b1;
               state_in = status.first_wins ? ST_RD_B : ST_WR_B;
            end
            ST_RD_B: begin
               cmd.rd_b = 1'b1;
               state_in = ST_WR_B;
            end
            ST_WR_B: begin
               cmd.wr_b = 1'b1;
               state_in = ST_FIN;
            end
            ST_FIN: begin
               cmd.line_step = 1'b1;
               state_in      = ST_IDLE;
            end
            default: state_in = ST_CLEAR;
         endcase
      end
   end

   // state and ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   `DDLS_ASSERT_IMP(a_no_accept_in_clear, clock, reset, cmd.clear_step, !ready_ff, "beat taken during clear pass")
   `DDLS_ASSERT_NXT(a_div_follows, clock, reset, cmd.div_start, state_ff == ST_DIV, "divider start lost")
   `DDLS_ASSERT_NXT(a_accept_leaves_idle, clock, reset, accept && !status.skip, state_ff != ST_IDLE, "accepted beat not processed")

endmodule

// ----- hw/rtl/depth_disparity_line_shift.sv -----
// Depth line shift: forward-warps depth lines horizontally by disparity.
// req_chan carries one depth pixel per beat in raster order (depth_in, drain);
// rsp_chan returns the warped pixel of the previous line at the same column,
// with line_end on its last column. A drain beat adds a column without a sample
// and is how the last line is pushed out; a drain with nothing pending is dropped.
// csr_we/csr_index/csr_wdata write baseline_focal_q8 (index 0) and line_width
// (index 1); a line_width write restarts the frame and clears the line stores.
// Each beat is worked one at a time: the next beat is not taken until the block
// is through with the last one, which for a scattered sample includes the
// 24-step serial divider that forms the shift and the writes to the line store;
// a dropped drain beat leaves the block ready for the next beat.
// rsp_valid rises after a beat that has a result passes the read-out and emit
// states. After reset and after a line_width write the store's
// 2*2^clog2(MAX_WIDTH) entries (4096 by default) are cleared one entry per
// cycle, with req_ready low. A stalled receiver holds the result in the output
// register and the block waits before placing the next result.
module depth_disparity_line_shift #(
   parameter int MAX_WIDTH = ddls_pkg::DEF_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   ddls_req_if.sink                       req_chan,
   ddls_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [ddls_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ddls_pkg::BF_W-1:0]      csr_wdata
);
   import ddls_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   function automatic logic [CW-1:0] last_column(input logic [LW_W-1:0] lw);
      int v;
      v = int'(lw);
      if (v < MIN_LINE_WIDTH) v = MIN_LINE_WIDTH;
      if (v > MAX_WIDTH) v = MAX_WIDTH;
      return CW'(v - 1);
   endfunction

   logic [BF_W-1:0] bf_ff;
   logic [CW-1:0]   last_col_ff;
   logic            restart;
   logic            ready;
   cmd_type         cmd;
   status_type      status;

   assign restart = csr_we && (csr_index == CSR_LINE_WIDTH);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bf_ff       <= '0;
         last_col_ff <= last_column(LW_W'(DEF_LINE_WIDTH));
      end else if (csr_we) begin
         if (csr_index == CSR_BASELINE_FOCAL) begin
            bf_ff <= csr_wdata;
         end else if (csr_index == CSR_LINE_WIDTH) begin
            last_col_ff <= last_column(csr_wdata[LW_W-1:0]);
         end
      end
   end

   assign req_chan.ready = ready;

   ddls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddls_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_depth      (req_chan.depth_in),
      .req_drain      (req_chan.drain),
      .baseline_focal (bf_ff),
      .last_col       (last_col_ff),
      .rsp_chan       (rsp_chan)
   );

endmodule

// ----- test/tb_depth_disparity_line_shift.sv -----
`timescale 1ns / 1ps

module tb_depth_disparity_line_shift;
   import ddls_pkg::*;

   localparam int  LINE_CELLS = DEF_MAX_WIDTH;
   localparam int  RUN_LIMIT  = 1500000;
   localparam int  SETTLE     = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               line_end;
   } pixel_type;

   typedef struct {
      logic [DEPTH_W-1:0] depth;
      bit                 drain;
      bit                 typed;
      pixel_type          want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BF_W-1:0]      csr_wdata;

   ddls_req_if req_bus ();
   ddls_rsp_if rsp_bus ();

   depth_disparity_line_shift i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the warp datapath
   logic [DEPTH_W-1:0] warp_cells [2][LINE_CELLS];
   bit                 cell_taken [2][LINE_CELLS];
   int unsigned        cur_col;
   bit                 cur_bank;
   bit                 out_line_ready;
   bit                 in_line_used;
   logic [BF_W-1:0]    bf_q8;
   logic [LW_W-1:0]    width_reg;

   pixel_type pending_pixels [$];
   int     error_count;
   int     cycle_count;
   int     send_idle_pct;
   int     rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned line_cells_used();
      int unsigned w;
      w = width_reg;
      if (w < MIN_LINE_WIDTH) w = MIN_LINE_WIDTH;
      if (w > LINE_CELLS) w = LINE_CELLS;
      return w;
   endfunction

   function automatic void clear_lines();
      for (int b = 0; b < 2; b++) begin
         for (int i = 0; i < LINE_CELLS; i++) begin
            warp_cells[b][i] = '0;
            cell_taken[b][i] = 1'b0;
         end
      end
      cur_col        = 0;
      cur_bank       = 1'b0;
      out_line_ready = 1'b0;
      in_line_used   = 1'b0;
   endfunction

   function automatic void mark_cell(int unsigned c, logic [DEPTH_W-1:0] d, bit first_wins);
      if (first_wins && cell_taken[cur_bank][c]) return;
      warp_cells[cur_bank][c] = d;
      cell_taken[cur_bank][c] = 1'b1;
   endfunction

   // move one sample by its disparity into the line being written
   function automatic void place_sample(int unsigned c, logic [DEPTH_W-1:0] d, int unsigned w);
      longint bf;
      longint s;
      if (d == 0) return;
      bf = longint'($signed(bf_q8));
      s  = longint'(c) + (bf + 128 * longint'(d)) / (256 * longint'(d));
      if (bf > 0) begin
         if (s >= 0 && s < longint'(w) - 1) begin
            mark_cell(int'(s), d, 1'b1);
            mark_cell(int'(s) + 1, d, 1'b1);
         end
      end else begin
         if (s > 0 && s < longint'(w)) begin
            mark_cell(int'(s), d, 1'b0);
            mark_cell(int'(s) - 1, d, 1'b0);
         end
      end
   endfunction

   // advance the shadow by one beat; returns 1 when a pixel comes out
   function automatic bit warp_beat(logic [DEPTH_W-1:0] d, bit drn, output pixel_type px);
      int unsigned w;
      int unsigned c;
      bit          last;
      bit          hit;
      w   = line_cells_used();
      c   = cur_col;
      hit = 1'b0;
      px  = '0;
      if (drn && !out_line_ready && !in_line_used) return 1'b0;
      if (c > w - 1) c = w - 1;
      last = (c == w - 1);
      if (out_line_ready) begin
         px.depth    = warp_cells[!cur_bank][c];
         px.line_end = last;
         warp_cells[!cur_bank][c] = '0;
         cell_taken[!cur_bank][c] = 1'b0;
         hit = 1'b1;
      end
      if (!drn) begin
         in_line_used = 1'b1;
         place_sample(c, d, w);
      end
      if (last) begin
         for (int i = 0; i < LINE_CELLS; i++) cell_taken[cur_bank][i] = 1'b0;
         cur_bank       = !cur_bank;
         out_line_ready = in_line_used;
         in_line_used   = 1'b0;
         cur_col        = 0;
      end else begin
         cur_col = c + 1;
      end
      return hit;
   endfunction

   // drive one beat, hold until taken, then idle at random
   task automatic send_beat(logic [DEPTH_W-1:0] d, bit drn, bit typed = 1'b0,
                            pixel_type want = '0);
      pixel_type px;
      req_bus.valid    <= 1'b1;
      req_bus.depth_in <= d;
      req_bus.drain    <= drn;
      do @(posedge clock); while (!req_bus.ready);
      if (warp_beat(d, drn, px)) pending_pixels.push_back(typed ? want : px);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // drop valid, let the result queue empty and the block settle
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [BF_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BASELINE_FOCAL) begin
         bf_q8 = val;
      end else if (idx == CSR_LINE_WIDTH) begin
         width_reg = val[LW_W-1:0];
         clear_lines();
      end
      @(posedge clock);
   endtask

   function automatic logic [DEPTH_W-1:0] pick_depth();
      int r;
      r = $urandom_range(99);
      if (r < 6) return '0;
      if (r < 30) return DEPTH_W'($urandom_range(1, 65535));
      return DEPTH_W'($urandom_range(1, 600));
   endfunction

   // whole lines with random content, a few broken by early drains, then flush
   task automatic run_lines(int beats);
      int unsigned w;
      int          sent;
      w    = line_cells_used();
      sent = 0;
      while (sent < beats) begin
         for (int unsigned c = 0; c < w; c++) begin
            send_beat(pick_depth(), $urandom_range(99) < 5);
            sent++;
         end
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, w)) send_beat(pick_depth(), 1'b1);
         end
      end
      repeat (w + $urandom_range(0, 2)) send_beat('0, 1'b1);
   endtask

   // score each returned pixel against the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel depth=%0d line_end=%0b", $time,
                     rsp_bus.aligned_depth, rsp_bus.line_end);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.aligned_depth !== want.depth) begin
               $display("%0t: aligned_depth expected %0d actual %0d", $time,
                        want.depth, rsp_bus.aligned_depth);
               error_count++;
            end
            if (rsp_bus.line_end !== want.line_end) begin
               $display("%0t: line_end expected %0b actual %0b", $time,
                        want.line_end, rsp_bus.line_end);
               error_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   stim_row_type directed [$];
   int unsigned  line_plan [$];

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_BASELINE_FOCAL;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.depth_in = '0;
      req_bus.drain    = 1'b0;
      rsp_bus.ready    = 1'b0;
      error_count      = 0;
      cycle_count      = 0;
      send_idle_pct    = 24;
      rsp_stall_pct    = 61;
      bf_q8            = '0;
      width_reg        = LW_W'(DEF_LINE_WIDTH);
      clear_lines();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero shift, width below range acts as two columns
      write_csr(CSR_LINE_WIDTH, '0);
      directed = '{
         '{16'd100,   1'b0, 1'b0, '0},
         '{16'd200,   1'b0, 1'b0, '0},
         '{16'd300,   1'b0, 1'b1, '{16'd200, 1'b0}},
         '{16'd400,   1'b0, 1'b1, '{16'd200, 1'b1}},
         '{16'd0,     1'b1, 1'b1, '{16'd400, 1'b0}},
         '{16'd0,     1'b1, 1'b1, '{16'd400, 1'b1}},
         '{16'hFFFF,  1'b1, 1'b0, '0},
         '{16'd0,     1'b0, 1'b0, '0},
         '{16'hFFFF,  1'b0, 1'b0, '0},
         '{16'd0,     1'b1, 1'b1, '{16'hFFFF, 1'b0}},
         '{16'd0,     1'b1, 1'b0, '0}
      };
      foreach (directed[i])
         send_beat(directed[i].depth, directed[i].drain, directed[i].typed, directed[i].want);
      settle_idle();

      // sign and extremes of the baseline, drain inside a line
      write_csr(CSR_LINE_WIDTH, LW_W'(8));
      write_csr(CSR_BASELINE_FOCAL, 32'h7FFF_FFFF);
      send_beat(16'd1, 1'b0);
      send_beat(16'hFFFF, 1'b0);
      send_beat(16'd40000, 1'b0);
      send_beat('0, 1'b1);
      send_beat(16'd8, 1'b0);
      repeat (3) send_beat(16'd1024, 1'b0);
      repeat (8) send_beat('0, 1'b1);
      settle_idle();
      write_csr(CSR_BASELINE_FOCAL, 32'h8000_0000);
      write_csr(CSR_SPARE_A, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE_B, 32'h1234_5678);
      send_beat(16'd1, 1'b0);
      send_beat(16'hFFFF, 1'b0);
      repeat (6) send_beat(16'd2000, 1'b0);
      repeat (8) send_beat('0, 1'b1);
      settle_idle();

      // widths at and past the top, no line completes
      write_csr(CSR_LINE_WIDTH, LW_W'(DEF_MAX_WIDTH));
      repeat (6) send_beat(pick_depth(), 1'b0);
      settle_idle();
      write_csr(CSR_LINE_WIDTH, '1);
      repeat (6) send_beat(pick_depth(), 1'b0);
      settle_idle();

      line_plan = '{2, 3, 5, 1, 8, 16, 4, 33, 12, 6};
      foreach (line_plan[p]) begin
         if (p == 3) begin
            send_idle_pct = 61;
            rsp_stall_pct = 24;
         end else if (p == 7) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         write_csr(CSR_LINE_WIDTH, LW_W'(line_plan[p]));
         case ($urandom_range(3))
            0: write_csr(CSR_BASELINE_FOCAL, $urandom());
            1: write_csr(CSR_BASELINE_FOCAL, -BF_W'($urandom_range(0, 1 << 20)));
            default: write_csr(CSR_BASELINE_FOCAL, BF_W'($urandom_range(0, 1 << 20)));
         endcase
         run_lines(36);
         settle_idle();
         // new baseline while the frame carries on
         write_csr(CSR_BASELINE_FOCAL, $urandom_range(1) ? BF_W'($urandom_range(0, 1 << 19))
                                                        : -BF_W'($urandom_range(0, 1 << 19)));
         run_lines(36);
         settle_idle();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
